// ===== design/bfs_pkg.sv =====
// Package for the bounded FIFO with statistics: widths, types, command codes
// and the saturating counter helper. No dependencies.
`default_nettype none

package bfs_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int VAL_W   = 32;
    localparam int OCC_W   = 11;
    localparam int CNT_W   = 63;
    localparam int CAP_W   = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [OCC_W-1:0]        occ_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [CAP_W-1:0]        cap_t;

    typedef enum logic
    {
        CMD_ADD = 1'b0,
        CMD_GET = 1'b1
    } cmd_t;

    // Result of one item, held between the memory read and the output register
    typedef struct packed
    {
        logic ok;
        logic get_ok;
        occ_t occupancy;
        cnt_t add_tries;
        cnt_t get_tries;
        cnt_t add_done;
        cnt_t get_done;
    } pend_t;

    function automatic cnt_t sat_inc(input cnt_t c);
        return (c == CNT_MAX) ? c : c + cnt_t'(1);
    endfunction

endpackage

`default_nettype wire

// ===== design/bfs_if.sv =====
// Valid/ready channel interfaces for the bounded FIFO with statistics.
// Depends on bfs_pkg for field widths.
`default_nettype none

interface bfs_in_if;
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    bfs_pkg::value_t      value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface bfs_out_if;
    logic                 valid;
    logic                 ready;
    logic                 ok;
    bfs_pkg::value_t      read_value;
    bfs_pkg::occ_t        occupancy;
    bfs_pkg::cnt_t        add_tries;
    bfs_pkg::cnt_t        get_tries;
    bfs_pkg::cnt_t        add_done;
    bfs_pkg::cnt_t        get_done;

    modport source (output valid, output ok, output read_value, output occupancy,
                    output add_tries, output get_tries, output add_done,
                    output get_done, input ready);
    modport sink   (input valid, input ok, input read_value, input occupancy,
                    input add_tries, input get_tries, input add_done,
                    input get_done, output ready);
endinterface

`default_nettype wire

// ===== design/bfs_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data when no read is issued
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/bounded_fifo_with_stats_core.sv =====
// Top level of the bounded FIFO with statistics: ring memory, pointers,
// counters and the result path. Depends on bfs_pkg, bfs_if and bfs_ram.
// Result path: an accepted item waits in the pending register for the memory read, then moves to the output register.
// Throughput: one item per cycle while results are taken; set by the
//   registered read of the ring memory feeding the output register.
// Reset: pointers, occupancy and counters clear, capacity_limit returns to
//   1024; the entry memory is not cleared and needs no clearing pass.
`default_nettype none

module bounded_fifo_with_stats_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire bfs_pkg::cap_t  cfg_wdata,
    bfs_in_if.sink              in_ch,
    bfs_out_if.source           out_ch
);

    import bfs_pkg::*;

    // Ring pointers, occupancy and statistics
    addr_t  head_reg;
    addr_t  tail_reg;
    occ_t   count_reg;
    cnt_t   add_tries_reg;
    cnt_t   get_tries_reg;
    cnt_t   add_done_reg;
    cnt_t   get_done_reg;
    cap_t   cap_reg;

    // Stage waiting on the memory read
    logic   pend_valid_reg;
    pend_t  pend_reg;
    pend_t  pend_next;

    // Output register
    logic   out_valid_reg;
    logic   ok_reg;
    value_t read_value_reg;
    occ_t   occupancy_reg;
    cnt_t   add_tries_out_reg;
    cnt_t   get_tries_out_reg;
    cnt_t   add_done_out_reg;
    cnt_t   get_done_out_reg;

    logic   accept;
    logic   advance;
    logic   is_get;
    logic   add_ok;
    logic   get_ok;
    occ_t   limit;
    addr_t  head_next;
    addr_t  tail_next;
    occ_t   count_next;
    cnt_t   add_tries_next;
    cnt_t   get_tries_next;
    cnt_t   add_done_next;
    cnt_t   get_done_next;
    value_t ram_rdata;

    // Advance the pending item into the output register when it is free or
    // being drained; take a new item in the same cycle.
    assign advance      = pend_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !pend_valid_reg || advance;
    assign accept       = in_ch.valid && in_ch.ready;

    // A limit above the ring size acts as the ring size
    assign limit  = (cap_reg > occ_t'(DEPTH)) ? occ_t'(DEPTH) : cap_reg;
    assign is_get = (in_ch.cmd == CMD_GET);
    // Refuse adds at or above the limit, even when the limit was lowered
    assign add_ok = !is_get && (count_reg < limit);
    assign get_ok = is_get && (count_reg != occ_t'(0));

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        add_tries_next = add_tries_reg;
        get_tries_next = get_tries_reg;
        add_done_next  = add_done_reg;
        get_done_next  = get_done_reg;
        if (is_get)
        begin
            get_tries_next = sat_inc(get_tries_reg);
            if (get_ok)
            begin
                head_next     = (head_reg == addr_t'(DEPTH - 1)) ? addr_t'(0)
                                                                 : head_reg + addr_t'(1);
                count_next    = count_reg - occ_t'(1);
                get_done_next = sat_inc(get_done_reg);
            end
        end
        else
        begin
            add_tries_next = sat_inc(add_tries_reg);
            if (add_ok)
            begin
                tail_next     = (tail_reg == addr_t'(DEPTH - 1)) ? addr_t'(0)
                                                                 : tail_reg + addr_t'(1);
                count_next    = count_reg + occ_t'(1);
                add_done_next = sat_inc(add_done_reg);
            end
        end

        pend_next.ok        = add_ok || get_ok;
        pend_next.get_ok    = get_ok;
        pend_next.occupancy = count_next;
        pend_next.add_tries = add_tries_next;
        pend_next.get_tries = get_tries_next;
        pend_next.add_done  = add_done_next;
        pend_next.get_done  = get_done_next;
    end

    // Entry store: write the tail on an accepted add, read the head on an
    // accepted get. Each transfer touches at most one entry and the write
    // lands before any later read, so no forwarding is needed.
    bfs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (accept && add_ok),
        .waddr (tail_reg),
        .wdata (in_ch.value),
        .re    (accept && get_ok),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            add_tries_reg  <= '0;
            get_tries_reg  <= '0;
            add_done_reg   <= '0;
            get_done_reg   <= '0;
            cap_reg        <= CAP_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end

            if (accept)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                count_reg     <= count_next;
                add_tries_reg <= add_tries_next;
                get_tries_reg <= get_tries_next;
                add_done_reg  <= add_done_next;
                get_done_reg  <= get_done_next;
            end

            if (accept)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= pend_next;
        end
        if (advance)
        begin
            ok_reg            <= pend_reg.ok;
            // drop the memory data unless this was a successful get
            read_value_reg    <= pend_reg.get_ok ? ram_rdata : value_t'(0);
            occupancy_reg     <= pend_reg.occupancy;
            add_tries_out_reg <= pend_reg.add_tries;
            get_tries_out_reg <= pend_reg.get_tries;
            add_done_out_reg  <= pend_reg.add_done;
            get_done_out_reg  <= pend_reg.get_done;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.ok         = ok_reg;
    assign out_ch.read_value = read_value_reg;
    assign out_ch.occupancy  = occupancy_reg;
    assign out_ch.add_tries  = add_tries_out_reg;
    assign out_ch.get_tries  = get_tries_out_reg;
    assign out_ch.add_done   = add_done_out_reg;
    assign out_ch.get_done   = get_done_out_reg;

endmodule

`default_nettype wire

// ===== test/bounded_fifo_with_stats_core_test.sv =====
// Self-checking testbench for bounded_fifo_with_stats_core: random and directed
// add/get traffic over valid/ready channels, checked against a local mirror.
// Depends on bfs_pkg, bfs_if and the block itself.
`default_nettype none

module bounded_fifo_with_stats_core_test;

    import bfs_pkg::*;

    typedef struct packed
    {
        cmd_t   cmd;
        value_t value;
    } fifo_op_t;

    typedef struct packed
    {
        logic   ok;
        value_t read_value;
        occ_t   occupancy;
        cnt_t   add_tries;
        cnt_t   get_tries;
        cnt_t   add_done;
        cnt_t   get_done;
    } fifo_status_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cap_t cfg_wdata;

    bfs_in_if  in_ch();
    bfs_out_if out_ch();

    bounded_fifo_with_stats_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Operations waiting for the driver, and status reports owed by the block
    fifo_op_t     op_backlog [$];
    fifo_status_t status_due [$];

    // Mirror of the queue: ring contents, pointers, occupancy, statistics
    value_t mirror_store [DEPTH];
    addr_t  mirror_head;
    addr_t  mirror_tail;
    occ_t   mirror_count;
    cnt_t   mirror_add_tries;
    cnt_t   mirror_get_tries;
    cnt_t   mirror_add_done;
    cnt_t   mirror_get_done;
    cap_t   mirror_limit;

    // Idle percentages of the sender and of the receiver
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Run statistics
    int unsigned fail_count;
    int unsigned transfers_in;
    int unsigned reports_checked;
    int unsigned peak_count;
    int unsigned head_wraps;
    int unsigned tail_wraps;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic cnt_t bump_saturating(input cnt_t c);
        return (&c) ? c : c + 1'b1;
    endfunction

    // Advance the mirror by one accepted operation and queue the status it owes
    task automatic apply_fifo_op(input cmd_t cmd, input value_t value);
        fifo_status_t st;
        occ_t         room;
        begin
            // A limit above the ring size acts as the ring size
            room = (mirror_limit > DEPTH) ? occ_t'(DEPTH) : occ_t'(mirror_limit);
            st.ok         = 1'b0;
            st.read_value = '0;
            if (cmd == CMD_ADD)
            begin
                mirror_add_tries = bump_saturating(mirror_add_tries);
                // Refuse when at or above the limit, even if the limit was lowered
                if (mirror_count < room)
                begin
                    mirror_store[mirror_tail] = value;
                    if (mirror_tail == addr_t'(DEPTH - 1))
                    begin
                        mirror_tail = '0;
                        tail_wraps++;
                    end
                    else
                        mirror_tail = mirror_tail + 1'b1;
                    mirror_count    = mirror_count + 1'b1;
                    mirror_add_done = bump_saturating(mirror_add_done);
                    st.ok           = 1'b1;
                end
            end
            else
            begin
                mirror_get_tries = bump_saturating(mirror_get_tries);
                if (mirror_count != '0)
                begin
                    st.read_value = mirror_store[mirror_head];
                    if (mirror_head == addr_t'(DEPTH - 1))
                    begin
                        mirror_head = '0;
                        head_wraps++;
                    end
                    else
                        mirror_head = mirror_head + 1'b1;
                    mirror_count    = mirror_count - 1'b1;
                    mirror_get_done = bump_saturating(mirror_get_done);
                    st.ok           = 1'b1;
                end
            end
            if (mirror_count > peak_count)
                peak_count = 32'(mirror_count);
            st.occupancy = mirror_count;
            st.add_tries = mirror_add_tries;
            st.get_tries = mirror_get_tries;
            st.add_done  = mirror_add_done;
            st.get_done  = mirror_get_done;
            status_due.push_back(st);
        end
    endtask

    // Driver: record each transfer at the edge it happens, then present the
    // next backlog operation or drop valid; one assignment per edge keeps
    // valid steady across back-to-back transfers.
    always @(posedge clk or negedge rst_n)
    begin
        fifo_op_t op;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.cmd   <= 1'b0;
            in_ch.value <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                apply_fifo_op(cmd_t'(in_ch.cmd), in_ch.value);
                transfers_in++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    op = op_backlog.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.cmd   <= op.cmd;
                    in_ch.value <= op.value;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each status transfer with the oldest owed status,
    // then pick the ready level for the next edge.
    always @(posedge clk or negedge rst_n)
    begin
        fifo_status_t want;
        fifo_status_t got;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.ok         = out_ch.ok;
                got.read_value = out_ch.read_value;
                got.occupancy  = out_ch.occupancy;
                got.add_tries  = out_ch.add_tries;
                got.get_tries  = out_ch.get_tries;
                got.add_done   = out_ch.add_done;
                got.get_done   = out_ch.get_done;
                if (status_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected status: ok=%0b val=%0d occ=%0d",
                                 got.ok, got.read_value, got.occupancy);
                end
                else
                begin
                    want = status_due.pop_front();
                    reports_checked++;
                    if (got.ok !== want.ok || got.read_value !== want.read_value ||
                        got.occupancy !== want.occupancy ||
                        got.add_tries !== want.add_tries ||
                        got.get_tries !== want.get_tries ||
                        got.add_done !== want.add_done ||
                        got.get_done !== want.get_done)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("status %0d expected: ok=%0b val=%0d occ=%0d %0d/%0d/%0d/%0d",
                                     reports_checked, want.ok, want.read_value,
                                     want.occupancy, want.add_tries, want.get_tries,
                                     want.add_done, want.get_done);
                            $display("status %0d actual:   ok=%0b val=%0d occ=%0d %0d/%0d/%0d/%0d",
                                     reports_checked, got.ok, got.read_value,
                                     got.occupancy, got.add_tries, got.get_tries,
                                     got.add_done, got.get_done);
                        end
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_op(input cmd_t cmd, input value_t value);
        fifo_op_t op;
        begin
            op.cmd   = cmd;
            op.value = value;
            op_backlog.push_back(op);
        end
    endtask

    // Queue n random operations, add_pct percent of them adds
    task automatic queue_random(input int n, input int unsigned add_pct);
        begin
            for (int i = 0; i < n; i++)
                queue_op(cmd_t'(($urandom_range(99) < add_pct) ? CMD_ADD : CMD_GET),
                         value_t'($urandom));
        end
    endtask

    // Hold until the backlog is sent and every owed status has arrived, then
    // let the result path settle; poll on the falling edge.
    task automatic wait_until_drained;
        begin
            do
                @(negedge clk);
            while (op_backlog.size() != 0 || in_ch.valid || status_due.size() != 0);
            repeat (4) @(negedge clk);
        end
    endtask

    // Write the capacity limit while the block is idle
    task automatic write_limit(input cap_t limit);
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= limit;
            @(posedge clk);
            cfg_we       <= 1'b0;
            mirror_limit  = limit;
        end
    endtask

    // Stimulus: directed corner cases, then random phases over several limits
    initial
    begin
        int fill_n;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        fail_count      = 0;
        transfers_in    = 0;
        reports_checked = 0;
        peak_count      = 0;
        head_wraps      = 0;
        tail_wraps      = 0;
        mirror_head      = '0;
        mirror_tail      = '0;
        mirror_count     = '0;
        mirror_add_tries = '0;
        mirror_get_tries = '0;
        mirror_add_done  = '0;
        mirror_get_done  = '0;
        mirror_limit     = CAP_RESET;
        for (int i = 0; i < DEPTH; i++)
            mirror_store[i] = '0;

        // Sender idles 30 percent, receiver 51 percent
        send_idle_pct = 30;
        recv_idle_pct = 51;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limit: get on empty, extreme values through and out in order
        queue_op(CMD_GET, value_t'(32'h1357_9BDF));
        queue_op(CMD_ADD, value_t'(32'h8000_0000));
        queue_op(CMD_ADD, value_t'(32'h7FFF_FFFF));
        queue_op(CMD_ADD, value_t'(32'h0000_0000));
        queue_op(CMD_ADD, value_t'(32'hFFFF_FFFF));
        repeat (4) queue_op(CMD_GET, value_t'($urandom));
        queue_op(CMD_GET, value_t'($urandom));
        wait_until_drained();

        // Zero limit: every add is refused
        write_limit(cap_t'(0));
        queue_op(CMD_ADD, value_t'(32'h1234_5678));
        queue_op(CMD_GET, value_t'(32'hFFFF_FFFF));
        wait_until_drained();

        // Limit of two: fill, then one refused add
        write_limit(cap_t'(2));
        queue_op(CMD_ADD, value_t'(32'hAAAA_AAAA));
        queue_op(CMD_ADD, value_t'(32'h5555_5555));
        queue_op(CMD_ADD, value_t'(32'h0F0F_0F0F));
        wait_until_drained();

        // Lower the limit below occupancy: adds refused, gets still drain
        write_limit(cap_t'(1));
        queue_op(CMD_ADD, value_t'(32'hF0F0_F0F0));
        repeat (3) queue_op(CMD_GET, value_t'($urandom));
        wait_until_drained();

        // Small limit, with a pause in the middle until all status is back
        write_limit(cap_t'(4));
        queue_random(30, 55);
        wait_until_drained();
        queue_random(20, 50);
        wait_until_drained();

        write_limit(cap_t'($urandom_range(1, 16)));
        queue_random(30, 50);
        wait_until_drained();

        // Swap the idle rates: sender 51 percent, receiver 30 percent
        send_idle_pct = 51;
        recv_idle_pct = 30;

        // Largest limit, above the ring size: fill to full, wrap the tail,
        // then push on a full ring
        write_limit(cap_t'(2047));
        fill_n = DEPTH - int'(mirror_count) + 4;
        for (int i = 0; i < fill_n; i++)
            queue_op(CMD_ADD, value_t'($urandom));
        queue_random(10, 50);
        wait_until_drained();

        // Limit exactly the ring size, near full
        write_limit(cap_t'(DEPTH));
        queue_random(20, 50);
        wait_until_drained();

        // No idling: a run of gets, then mixed traffic
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(cap_t'(1500));
        repeat (60) queue_op(CMD_GET, value_t'($urandom));
        queue_random(40, 50);
        wait_until_drained();

        write_limit(cap_t'($urandom_range(0, 2047)));
        queue_random(30, 55);
        wait_until_drained();

        // Let any stray status surface before the verdict
        repeat (8) @(posedge clk);
        if (status_due.size() != 0)
            fail_count++;

        $display("covered %0d transfers and %0d status checks, limits 0 to 2047,",
                 transfers_in, reports_checked);
        $display("peak occupancy %0d, head wrapped %0d and tail wrapped %0d times",
                 peak_count, head_wraps, tail_wraps);
        if (fail_count == 0)
            $display("bounded_fifo_with_stats_core: match");
        else
            $display("bounded_fifo_with_stats_core: mismatch");
        $finish;
    end

    // Watchdog: end a hung run
    initial
    begin
        #10_000_000;
        $display("bounded_fifo_with_stats_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
